>>> hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master transaction block.
`timescale 1ns / 1ps
package i2cm_pkg;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_S1    = 4'd1,
		PH_S2    = 4'd2,
		PH_S3    = 4'd3,
		PH_WAITD = 4'd4,
		PH_BLOW  = 4'd5,
		PH_BHIGH = 4'd6,
		PH_ALOW  = 4'd7,
		PH_AHIGH = 4'd8,
		PH_P1    = 4'd9,
		PH_P2    = 4'd10,
		PH_P3    = 4'd11
	} phase_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HOLD_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_HOLD_TICKS  = 3'd4;

	localparam logic [6:0]  RST_DEVICE_ADDRESS   = 7'd16;
	localparam logic [15:0] RST_LOW_TICKS        = 16'd70;
	localparam logic [15:0] RST_HIGH_TICKS       = 16'd26;
	localparam logic [15:0] RST_START_HOLD_TICKS = 16'd24;
	localparam logic [15:0] RST_STOP_HOLD_TICKS  = 16'd50;

	typedef struct packed {
		logic       start_request;
		logic       operation;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       write_byte_valid;
		logic       sda_sample;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       read_last;
		logic       write_taken;
		logic       ack_status;
		logic       busy_res;
		logic       done_res;
	} res_item_t;

endpackage

>>> hw/rtl/i2cm_if.sv
// Channel interfaces: tick commands, per-tick results and register writes.
`timescale 1ns / 1ps
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic       start_request;
	logic       operation;
	logic [7:0] byte_count;
	logic [7:0] write_byte;
	logic       write_byte_valid;
	logic       sda_sample;

	modport source (output valid, start_request, operation, byte_count, write_byte,
		write_byte_valid, sda_sample, input ready);
	modport sink (input valid, start_request, operation, byte_count, write_byte,
		write_byte_valid, sda_sample, output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       read_last;
	logic       write_taken;
	logic       ack_status;
	logic       busy_res;
	logic       done_res;

	modport source (output valid, scl_level, sda_level, sda_drive, read_byte, read_valid,
		read_last, write_taken, ack_status, busy_res, done_res, input ready);
	modport sink (input valid, scl_level, sda_level, sda_drive, read_byte, read_valid,
		read_last, write_taken, ack_status, busy_res, done_res, output ready);
endinterface

interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/i2cm_queue.sv
// Front end: accepts tick commands into a two-entry queue.
`timescale 1ns / 1ps
module i2cm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	i2cm_cmd_if.sink             cmd,
	output logic                 q_valid,
	output i2cm_pkg::cmd_item_t  q_item,
	input  logic                 q_pop
);
	import i2cm_pkg::*;

	cmd_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign cmd.ready = (count_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (count_q != 2'd0);
	assign pop       = q_pop && q_valid;
	assign q_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{
				start_request:    cmd.start_request,
				operation:        cmd.operation,
				byte_count:       cmd.byte_count,
				write_byte:       cmd.write_byte,
				write_byte_valid: cmd.write_byte_valid,
				sda_sample:       cmd.sda_sample
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

>>> hw/rtl/i2cm_seq.sv
// Back end: bus sequencer, configuration registers and result register.
`timescale 1ns / 1ps
module i2cm_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  i2cm_pkg::cmd_item_t  q_item,
	output logic                 q_pop,
	i2cm_cfg_if.sink             cfg,
	i2cm_res_if.source           res
);
	import i2cm_pkg::*;

	logic [6:0]  dev_addr_q;
	logic [15:0] low_ticks_q;
	logic [15:0] high_ticks_q;
	logic [15:0] start_hold_q;
	logic [15:0] stop_hold_q;

	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [2:0]  bit_q, bit_d;
	logic [7:0]  bytes_q, bytes_d;
	logic [7:0]  shift_q, shift_d;
	logic        dir_q, dir_d;
	logic        ack_q, ack_d;
	logic        saddr_q, saddr_d;

	res_item_t   out_q, res_d;
	logic        out_valid_q;

	logic        tx;
	logic [15:0] len;
	logic        at_end;
	logic        scl, sda, drv;
	logic [7:0]  bytes_nx;

	assign cfg.ready = 1'b1;
	assign q_pop     = q_valid && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q   <= RST_DEVICE_ADDRESS;
			low_ticks_q  <= RST_LOW_TICKS;
			high_ticks_q <= RST_HIGH_TICKS;
			start_hold_q <= RST_START_HOLD_TICKS;
			stop_hold_q  <= RST_STOP_HOLD_TICKS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DEVICE_ADDRESS:   dev_addr_q   <= cfg.data[6:0];
				CFG_LOW_TICKS:        low_ticks_q  <= cfg.data;
				CFG_HIGH_TICKS:       high_ticks_q <= cfg.data;
				CFG_START_HOLD_TICKS: start_hold_q <= cfg.data;
				CFG_STOP_HOLD_TICKS:  stop_hold_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= 16'd0;
			bit_q   <= 3'd7;
			bytes_q <= 8'd0;
			shift_q <= 8'd0;
			dir_q   <= 1'b0;
			ack_q   <= 1'b0;
			saddr_q <= 1'b0;
		end else if (q_pop) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			bytes_q <= bytes_d;
			shift_q <= shift_d;
			dir_q   <= dir_d;
			ack_q   <= ack_d;
			saddr_q <= saddr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) out_q <= res_d;
	end

	always_comb begin
		unique case (phase_q)
			PH_S1, PH_S2, PH_S3, PH_P2: len = start_hold_q;
			PH_BLOW, PH_ALOW, PH_P1:    len = low_ticks_q;
			PH_BHIGH, PH_AHIGH:         len = high_ticks_q;
			PH_P3:                      len = stop_hold_q;
			default:                    len = 16'd1;
		endcase
	end

	always_comb begin
		tx       = saddr_q || !dir_q;
		at_end   = ({1'b0, tick_q} + 17'd1) >= {1'b0, len};
		bytes_nx = (!saddr_q && bytes_q != 8'd0) ? bytes_q - 8'd1 : bytes_q;

		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		bytes_d = bytes_q;
		shift_d = shift_q;
		dir_d   = dir_q;
		ack_d   = ack_q;
		saddr_d = saddr_q;
		res_d   = '0;

		scl = 1'b1;
		sda = 1'b1;
		drv = 1'b1;
		unique case (phase_q)
			PH_S2: sda = 1'b0;
			PH_S3, PH_WAITD, PH_P1: begin
				scl = 1'b0;
				sda = 1'b0;
			end
			PH_BLOW, PH_BHIGH: begin
				scl = (phase_q == PH_BHIGH);
				if (tx) sda = shift_q[bit_q];
				else drv = 1'b0;
			end
			PH_ALOW, PH_AHIGH: begin
				scl = (phase_q == PH_AHIGH);
				if (tx) drv = 1'b0;
				else sda = (bytes_q == 8'd1);
			end
			PH_P2: sda = 1'b0;
			default: ;
		endcase

		if (!at_end && phase_q != PH_IDLE && phase_q != PH_WAITD) begin
			tick_d = tick_q + 16'd1;
		end else begin
			tick_d = 16'd0;
			unique case (phase_q)
				PH_IDLE: begin
					if (q_item.start_request) begin
						dir_d   = q_item.operation;
						bytes_d = q_item.byte_count;
						shift_d = {dev_addr_q, q_item.operation};
						saddr_d = 1'b1;
						bit_d   = 3'd7;
						phase_d = PH_S1;
					end
				end
				PH_S1: phase_d = PH_S2;
				PH_S2: phase_d = PH_S3;
				PH_S3: phase_d = PH_BLOW;
				PH_WAITD: begin
					if (q_item.write_byte_valid) begin
						shift_d           = q_item.write_byte;
						res_d.write_taken = 1'b1;
						bit_d             = 3'd7;
						phase_d           = PH_BLOW;
					end
				end
				PH_BLOW: phase_d = PH_BHIGH;
				PH_BHIGH: begin
					if (!tx) shift_d[bit_q] = q_item.sda_sample;
					bit_d   = bit_q - 3'd1;
					phase_d = (bit_q == 3'd0) ? PH_ALOW : PH_BLOW;
				end
				PH_ALOW: phase_d = PH_AHIGH;
				PH_AHIGH: begin
					if (tx) begin
						ack_d = q_item.sda_sample;
					end else begin
						res_d.read_valid = 1'b1;
						res_d.read_byte  = shift_q;
						res_d.read_last  = (bytes_q == 8'd1);
					end
					bytes_d = bytes_nx;
					saddr_d = 1'b0;
					bit_d   = 3'd7;
					if (bytes_nx == 8'd0) begin
						phase_d = PH_P1;
					end else if (!dir_q) begin
						phase_d = PH_WAITD;
					end else begin
						shift_d = 8'd0;
						phase_d = PH_BLOW;
					end
				end
				PH_P1: phase_d = PH_P2;
				PH_P2: phase_d = PH_P3;
				PH_P3: begin
					res_d.done_res = 1'b1;
					phase_d        = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		res_d.scl_level  = scl;
		res_d.sda_level  = drv ? sda : 1'b1;
		res_d.sda_drive  = drv;
		res_d.ack_status = ack_d;
		res_d.busy_res   = (phase_d != PH_IDLE);
	end

	assign res.valid       = out_valid_q;
	assign res.scl_level   = out_q.scl_level;
	assign res.sda_level   = out_q.sda_level;
	assign res.sda_drive   = out_q.sda_drive;
	assign res.read_byte   = out_q.read_byte;
	assign res.read_valid  = out_q.read_valid;
	assign res.read_last   = out_q.read_last;
	assign res.write_taken = out_q.write_taken;
	assign res.ack_status  = out_q.ack_status;
	assign res.busy_res    = out_q.busy_res;
	assign res.done_res    = out_q.done_res;
endmodule

>>> hw/rtl/i2c_master_transaction.sv
// Top level of the tick-driven I2C master transaction block.
//
// Each cmd transaction is one time tick: start request, direction, byte
// count, the next write byte with its valid flag and the sampled SDA level.
// Each tick yields exactly one res transaction: SCL/SDA levels and SDA
// enable for that tick, a completed read byte, write-byte taken, last
// acknowledge, busy and done flags. Ticks and results stay in order.
// Register writes on cfg (index 0 device address, 1 low ticks, 2 high
// ticks, 3 start hold ticks, 4 stop hold ticks) are taken every cycle and
// belong in idle periods; other indexes are ignored.
// Each accepted tick passes through the queue and then the result register
// before its result is offered on res. Throughput: one tick per cycle while
// the receiver takes each result, as the sequencer steps once per tick.
// A two-entry queue decouples cmd from the sequencer; a result register
// holds res while the receiver stalls, and cmd backs up once the queue
// fills. Reset (arst_n low) returns the bus to idle, empties the queue and
// result register, and restores the register defaults.
`timescale 1ns / 1ps
module i2c_master_transaction (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_cmd_if.sink   cmd,
	i2cm_res_if.source res,
	i2cm_cfg_if.sink   cfg
);
	import i2cm_pkg::*;

	logic      q_valid;
	logic      q_pop;
	cmd_item_t q_item;

	i2cm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	i2cm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.cfg     (cfg),
		.res     (res)
	);
endmodule

>>> hw/rtl/i2cm_checker.sv
// Port-level checks for the I2C master transaction block, bound to the top.
`timescale 1ns / 1ps
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       sda_level,
	input logic       sda_drive,
	input logic [7:0] read_byte,
	input logic       read_valid,
	input logic       read_last,
	input logic       write_taken,
	input logic       busy_res,
	input logic       done_res
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !sda_drive |-> sda_level)
		else $error("released SDA not reported high");

	a_no_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !read_valid |-> read_byte == 8'd0 && !read_last)
		else $error("read fields set without a read byte");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res && !write_taken && !read_valid)
		else $error("done tick not idle");
endmodule

bind i2c_master_transaction i2cm_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.sda_level   (res.sda_level),
	.sda_drive   (res.sda_drive),
	.read_byte   (res.read_byte),
	.read_valid  (res.read_valid),
	.read_last   (res.read_last),
	.write_taken (res.write_taken),
	.busy_res    (res.busy_res),
	.done_res    (res.done_res)
);
